[rtl/core/bwcf_pkg.sv]
// Shared types, register codes and helpers for the box wall collision unit.
package bwcf_pkg;

  // Q16.16 word width
  localparam int unsigned W = 32;
  localparam int unsigned COEFF_W = 17;

  // Reset values of the wall registers
  localparam logic [W-1:0] BOX_MIN_RST = 32'h0000_0000;
  localparam logic [W-1:0] BOX_MAX_RST = 32'h0001_0000;
  localparam logic [COEFF_W-1:0] COEFF_RST = 17'h0_0000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MIN_Z = 3'd4,
    REG_MAX_Z = 3'd5,
    REG_COEFF = 3'd6
  } cfg_reg_t;

  // One particle in flight; component 0 is the axis under test
  typedef struct packed {
    logic        stuck;
    logic [2:0][W-1:0] vel;
    logic [2:0][W-1:0] pos;
  } pkt_t;

  // Rotate components so the next axis sits at index 0
  function automatic pkt_t rot(input pkt_t p);
    pkt_t r;
    r = p;
    r.pos[0] = p.pos[1];
    r.pos[1] = p.pos[2];
    r.pos[2] = p.pos[0];
    r.vel[0] = p.vel[1];
    r.vel[1] = p.vel[2];
    r.vel[2] = p.vel[0];
    return r;
  endfunction

endpackage

[rtl/core/bwcf_axis.sv]
// One axis of wall collision: test, friction, square root and divide, pipelined.
module bwcf_axis
  import bwcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  pkt_t               in_item,
  input  logic [W-1:0]       lo,
  input  logic [W-1:0]       hi,
  input  logic [COEFF_W-1:0] coeff,
  output logic               out_valid,
  output pkt_t               out_item
);

  localparam int unsigned NSQ = 32;
  localparam int unsigned SQ0 = 4;
  localparam int unsigned NDV = 32;
  localparam int unsigned DV0 = SQ0 + NSQ + 1;
  localparam int unsigned NST = DV0 + NDV + 1;

  typedef struct packed {
    pkt_t        pk;
    logic        act;
    logic        stick;
    logic [W-1:0] m;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W:0]   fm;
  } ctl_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  logic       vl [0:NST];
  ctl_t       ct [0:NST-1];

  logic [63:0] sqa, sqb, sum_d, fm2_d;
  logic [63:0] sn [0:NSQ];
  logic [63:0] sr [0:NSQ];
  logic [63:0] da [0:NDV];
  logic [63:0] db [0:NDV];
  logic [W-1:0] ln [0:NDV];

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NST; i++) vl[i] <= 1'b0;
    end else if (ce) begin
      vl[0] <= in_valid;
      for (int i = 1; i <= NST; i++) vl[i] <= vl[i-1];
    end
  end

  // stage A: incoming particle with cleared control fields
  ctl_t a_ctl;
  always_comb begin
    a_ctl    = '0;
    a_ctl.pk = in_item;
  end

  // stage B: wall test and magnitudes
  ctl_t b_ctl;
  logic b_low, b_up;
  always_comb begin
    b_ctl = ct[0];
    b_low = $signed(ct[0].pk.pos[0]) <= $signed(lo);
    b_up  = !b_low && ($signed(ct[0].pk.pos[0]) >= $signed(hi));
    b_ctl.act = !ct[0].pk.stuck &&
                ((b_low && ct[0].pk.vel[0][W-1]) ||
                 (b_up && !ct[0].pk.vel[0][W-1] && (ct[0].pk.vel[0] != '0)));
    b_ctl.m  = b_low ? (W'(0) - ct[0].pk.vel[0]) : ct[0].pk.vel[0];
    b_ctl.ma = mag(ct[0].pk.vel[1]);
    b_ctl.mb = mag(ct[0].pk.vel[2]);
  end

  // stage C: friction magnitude and tangential squares
  logic [48:0] c_prod;
  assign c_prod = 49'(coeff) * 49'(ct[1].m);

  ctl_t c_ctl;
  always_comb begin
    c_ctl    = ct[1];
    c_ctl.fm = c_prod[48:16];
  end

  // stage E control: static test result
  ctl_t e_ctl;
  always_comb begin
    e_ctl       = ct[3];
    e_ctl.stick = ct[3].act && (ct[3].fm[W] || (sum_d <= fm2_d));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ct[0]    <= a_ctl;
      ct[1]    <= b_ctl;
      ct[2]    <= c_ctl;
      sqa      <= 64'(ct[1].ma) * 64'(ct[1].ma);
      sqb      <= 64'(ct[1].mb) * 64'(ct[1].mb);
      // stage D: sum and friction square
      ct[3]    <= ct[2];
      sum_d    <= sqa + sqb;
      fm2_d    <= 64'(ct[2].fm[W-1:0]) * 64'(ct[2].fm[W-1:0]);
      // stage E: static test, start root
      ct[SQ0]  <= e_ctl;
      sn[0]    <= sum_d;
      sr[0]    <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = sr[k] + BITK;
    assign ge    = sn[k] >= trial;
    always_ff @(posedge clk) begin
      if (ce) begin
        ct[SQ0+k+1] <= ct[SQ0+k];
        sn[k+1]     <= ge ? (sn[k] - trial) : sn[k];
        sr[k+1]     <= ge ? ((sr[k] >> 1) + BITK) : (sr[k] >> 1);
      end
    end
  end

  // stage P: dividends for both tangential components
  always_ff @(posedge clk) begin
    if (ce) begin
      ct[DV0] <= ct[DV0-1];
      ln[0]   <= sr[NSQ][W-1:0];
      da[0]   <= 64'(ct[DV0-1].ma) * 64'(ct[DV0-1].fm[W-1:0]);
      db[0]   <= 64'(ct[DV0-1].mb) * 64'(ct[DV0-1].fm[W-1:0]);
    end
  end

  // restoring divide, one quotient bit per stage, both components side by side
  for (genvar j = 0; j < NDV; j++) begin : g_div
    logic [64:0] ta, tb;
    logic [W:0]  ha, hb;
    logic        gea, geb;
    logic [W:0]  ra, rb;
    assign ta  = {da[j], 1'b0};
    assign tb  = {db[j], 1'b0};
    assign ha  = ta[64:32];
    assign hb  = tb[64:32];
    assign gea = ha >= {1'b0, ln[j]};
    assign geb = hb >= {1'b0, ln[j]};
    assign ra  = gea ? (ha - {1'b0, ln[j]}) : ha;
    assign rb  = geb ? (hb - {1'b0, ln[j]}) : hb;
    always_ff @(posedge clk) begin
      if (ce) begin
        ct[DV0+j+1] <= ct[DV0+j];
        ln[j+1]     <= ln[j];
        da[j+1]     <= {ra[W-1:0], ta[31:1], gea};
        db[j+1]     <= {rb[W-1:0], tb[31:1], geb};
      end
    end
  end

  // stage F: apply stop or dynamic friction
  ctl_t fc;
  pkt_t f_pk;
  logic [W-1:0] fra, frb;
  always_comb begin
    fc   = ct[NST-1];
    f_pk = fc.pk;
    fra  = fc.ma - da[NDV][W-1:0];
    frb  = fc.mb - db[NDV][W-1:0];
    if (fc.stick) begin
      f_pk.vel   = '0;
      f_pk.stuck = 1'b1;
    end else if (fc.act) begin
      f_pk.vel[0] = '0;
      f_pk.vel[1] = fc.pk.vel[1][W-1] ? (W'(0) - fra) : fra;
      f_pk.vel[2] = fc.pk.vel[2][W-1] ? (W'(0) - frb) : frb;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) out_item <= f_pk;
  end

  assign out_valid = vl[NST];

endmodule

[rtl/core/box_wall_collision_friction_unit.sv]
// Top level: box wall collision with Coulomb friction, three axis pipelines in a row.
//
// Input stream s_*: one particle per transfer, positions and velocities in
// signed Q16.16. Output stream m_*: the velocity after collision and the
// stuck flag, one result per input, in input order.
// The configuration port writes the box walls and the friction coefficient
// by register index; a write to an unused index is dropped. Write only while
// the pipeline is empty.
// Throughput: one particle per cycle while m_tready lets the pipeline
// advance. Each axis takes 71 register stages, set by the square root
// (one root bit per stage) and the divide (one quotient bit per stage),
// and the first stage loads at the input transfer edge.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the unit box with zero friction.
module box_wall_collision_friction_unit
  import bwcf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each)
  input  logic [191:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // new_vel_x, new_vel_y, new_vel_z (32 bits each), stuck, 7 zero bits
  output logic [103:0] m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [2:0][W-1:0]   box_lo, box_hi;
  logic [COEFF_W-1:0]  coeff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo <= {3{BOX_MIN_RST}};
      box_hi <= {3{BOX_MAX_RST}};
      coeff  <= COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: box_lo[0] <= cfg_data;
        REG_MAX_X: box_hi[0] <= cfg_data;
        REG_MIN_Y: box_lo[1] <= cfg_data;
        REG_MAX_Y: box_hi[1] <= cfg_data;
        REG_MIN_Z: box_lo[2] <= cfg_data;
        REG_MAX_Z: box_hi[2] <= cfg_data;
        REG_COEFF: coeff     <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being taken
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  pkt_t in_pk;
  always_comb begin
    in_pk       = '0;
    in_pk.pos   = s_tdata[95:0];
    in_pk.vel   = s_tdata[191:96];
    in_pk.stuck = 1'b0;
  end

  logic vx, vy, vz;
  pkt_t px, py, pz, res;

  // x axis, then y and z with components rotated to the front
  bwcf_axis u_ax_x (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(s_tvalid), .in_item(in_pk),
    .lo(box_lo[0]), .hi(box_hi[0]), .coeff(coeff),
    .out_valid(vx), .out_item(px)
  );

  bwcf_axis u_ax_y (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(vx), .in_item(rot(px)),
    .lo(box_lo[1]), .hi(box_hi[1]), .coeff(coeff),
    .out_valid(vy), .out_item(py)
  );

  bwcf_axis u_ax_z (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(vy), .in_item(rot(py)),
    .lo(box_lo[2]), .hi(box_hi[2]), .coeff(coeff),
    .out_valid(vz), .out_item(pz)
  );

  // back to x, y, z order
  assign res      = rot(pz);
  assign m_tvalid = vz;
  assign m_tdata  = {7'd0, res.stuck, res.vel};

endmodule

[tb/testbench.sv]
// Self-checking testbench for the box wall collision and friction unit.
module testbench
  import bwcf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Expected velocity and stuck flag for one particle
  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic               stuck;
  } bounce_t;

  // Box walls and friction as written into the block
  class wall_box;
    logic signed [31:0] lo[3];
    logic signed [31:0] hi[3];
    logic [16:0]        mu;
    bounce_t            pending[$];
    int                 errors;
    int                 checked;

    function void clear();
      for (int a = 0; a < 3; a++) begin
        lo[a] = BOX_MIN_RST;
        hi[a] = BOX_MAX_RST;
      end
      mu = COEFF_RST;
    endfunction

    function void write(cfg_reg_t r, logic [31:0] d);
      case (r)
        REG_MIN_X: lo[0] = d;
        REG_MAX_X: hi[0] = d;
        REG_MIN_Y: lo[1] = d;
        REG_MAX_Y: hi[1] = d;
        REG_MIN_Z: lo[2] = d;
        REG_MAX_Z: hi[2] = d;
        REG_COEFF: mu = d[16:0];
        default: ;
      endcase
    endfunction

    // Integer square root, floor
    function automatic logic [63:0] root(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Reduce one tangential component by dynamic friction
    function automatic longint slide(longint c, logic [63:0] fm, logic [63:0] len);
      logic [63:0] a, q;
      a = (c < 0) ? -c : c;
      q = (a * fm) / len;
      return (c < 0) ? -longint'(a - q) : longint'(a - q);
    endfunction

    // Predict the bounce for one accepted particle
    function void note(logic [191:0] d);
      longint p[3], v[3], vn;
      logic [63:0] m, fm, ma, mb, s, len;
      bounce_t b;
      int ta, tb;
      b.stuck = 0;
      for (int i = 0; i < 3; i++) begin
        p[i] = $signed(d[32*i +: 32]);
        v[i] = $signed(d[32*(i+3) +: 32]);
      end
      for (int a = 0; a < 3; a++) begin
        ta = (a + 1) % 3;
        tb = (a + 2) % 3;
        if (p[a] <= lo[a]) vn = v[a];
        else if (p[a] >= hi[a]) vn = -v[a];
        else continue;
        if (vn >= 0) continue;
        m = -vn;
        fm = (64'(mu) * m) >> 16;
        ma = (v[ta] < 0) ? -v[ta] : v[ta];
        mb = (v[tb] < 0) ? -v[tb] : v[tb];
        s = ma * ma + mb * mb;
        if (fm >= 64'h1_0000_0000 || s <= fm * fm) begin
          v[0] = 0; v[1] = 0; v[2] = 0;
          b.stuck = 1;
          break;
        end
        len = root(s);
        v[a] = 0;
        v[ta] = slide(v[ta], fm, len);
        v[tb] = slide(v[tb], fm, len);
      end
      b.vx = v[0][31:0];
      b.vy = v[1][31:0];
      b.vz = v[2][31:0];
      pending = {pending, b};
    endfunction

    // Compare one result with the oldest expectation
    function void check(logic [103:0] d);
      bounce_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[31:0] !== e.vx) begin
        $display("%0t new_vel_x exp %h got %h", $realtime, e.vx, d[31:0]);
        errors++;
      end
      if (d[63:32] !== e.vy) begin
        $display("%0t new_vel_y exp %h got %h", $realtime, e.vy, d[63:32]);
        errors++;
      end
      if (d[95:64] !== e.vz) begin
        $display("%0t new_vel_z exp %h got %h", $realtime, e.vz, d[95:64]);
        errors++;
      end
      if (d[96] !== e.stuck) begin
        $display("%0t stuck exp %b got %b", $realtime, e.stuck, d[96]);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 212;

  logic         clk = 0;
  logic         rst = 1;
  logic [191:0] s_tdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [103:0] m_tdata;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  wall_box box = new();
  int  idle_pct = 33;      // sender gap rate
  int  sink_pct = 33;      // receiver stall rate
  int  hold_off = 0;       // cycles of forced receiver stall
  int  sent = 0;
  int  stuck_seen = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  box_wall_collision_friction_unit i_dut (.*);

  // Receiver: random stalls, optional long hold-off, checks each transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (m_tdata[96]) stuck_seen++;
        box.check(m_tdata);
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_pct);
      end
    end
  end

  // One register write; cfg_we drops and the task idles before returning
  task automatic cfg_write(cfg_reg_t r, logic [31:0] d);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    box.write(r, d);
    @(posedge clk);
  endtask

  // Offer one particle, with a random gap first; tvalid stays high afterwards
  task automatic send(logic [191:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    box.note(d);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (box.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(131072) - 65536;
      3: return $urandom_range(8) << 15;
      default: return $urandom;
    endcase
  endfunction

  // Particle aimed at the walls: positions mostly near or past them, velocities mostly moderate
  function automatic logic [191:0] rnd_hit();
    logic [191:0] d;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(3))
        0: d[32*a +: 32] = box.lo[a] - $urandom_range(3);
        1: d[32*a +: 32] = box.hi[a] + $urandom_range(3);
        2: d[32*a +: 32] = box.lo[a] + $urandom_range(65536);
        default: d[32*a +: 32] = $urandom;
      endcase
      if ($urandom_range(9) == 0) d[32*(a+3) +: 32] = rnd_word();
      else d[32*(a+3) +: 32] = $urandom_range(400000) - 200000;
    end
    return d;
  endfunction

  function automatic logic [191:0] pk(int px, int py, int pz, int vx, int vy, int vz);
    return {32'(vz), 32'(vy), 32'(vx), 32'(pz), 32'(py), 32'(px)};
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++)
      send(($urandom_range(4) == 0) ? {$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom} : rnd_hit());
  endtask

  initial begin
    #400000;
    $display("box_wall_collision_friction_unit regression: fail");
    $finish;
  end

  initial begin
    box.clear();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset box, frictionless bounces
    send(pk(0, 32768, 32768, -65536, 0, 0));
    send(pk(65536, 32768, 32768, 65536, 100, 0));
    send(pk(32768, 32768, 32768, 5, 5, 5));
    send(pk(-1, -1, -1, 5, 5, 5));
    send(pk(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff));
    drain();

    // Full friction: static stop and dynamic slide
    cfg_write(REG_COEFF, 32'h1_0000);
    send(pk(0, 32768, 32768, -65536, 1000, 1000));
    send(pk(0, 32768, 32768, -100, 60000, -60000));
    send(pk(0, 0, 0, -65536, -65536, -65536));
    send(pk(0, 32768, 32768, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send(pk(0, 32768, 32768, -3, 32'h7fff_ffff, 32'h7fff_ffff));
    drain();

    // Inverted box and widest walls, coefficient above 1.0
    cfg_write(REG_MIN_X, 32'h0002_0000);
    cfg_write(REG_MAX_X, 32'h0000_0000);
    cfg_write(REG_MIN_Y, 32'h8000_0000);
    cfg_write(REG_MAX_Y, 32'h7fff_ffff);
    cfg_write(REG_MIN_Z, 32'hffff_0000);
    cfg_write(REG_MAX_Z, 32'hffff_0000);
    cfg_write(REG_COEFF, 32'h1_ffff);
    send(pk(65536, 0, -65536, -10, 20000, 30000));
    send(pk(65536, 32'h8000_0000, -65536, 10, 5, -7));
    send(pk(65536, 32'h7fff_ffff, 0, 10, 50, -7));
    send(pk(32'h7fff_ffff, 0, -65536, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    drain();

    // Random phases over several box settings
    for (int ph = 0; ph < 5; ph++) begin
      for (int r = REG_MIN_X; r <= REG_MAX_Z; r++)
        cfg_write(cfg_reg_t'(r), (r % 2) ? $urandom_range(300000)
                                         : -$urandom_range(300000));
      cfg_write(REG_COEFF, (ph == 0) ? 0 : (ph == 4) ? 32'h1_ffff
                                     : $urandom_range(65536));
      if (ph == 2) begin
        idle_pct = 0;
        sink_pct = 0;
      end else begin
        idle_pct = 33;
        sink_pct = 33;
      end
      if (ph == 3) hold_off = 400;  // long receiver stall, input backs up
      random_phase(135);
      drain();  // sender pauses until all results are in
    end

    $display("%0d particles sent, %0d results checked, %0d static stops",
             sent, box.checked, stuck_seen);
    $display("covered reset, inverted and extreme walls, coefficients 0 to max");
    if (box.errors == 0 && box.pending.size() == 0)
      $display("box_wall_collision_friction_unit regression: pass");
    else
      $display("box_wall_collision_friction_unit regression: fail");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/bwcf_pkg.sv
rtl/core/bwcf_axis.sv
rtl/core/box_wall_collision_friction_unit.sv
tb/testbench.sv
